FILE: src/stsh_pkg.sv
package stsh_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int KEY_W       = 64;
  localparam int CMD_W       = 2;

  typedef logic [CMD_W-1:0] cmd_code_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [KEY_W-1:0] key_t;

  localparam cmd_code_t CMD_LOAD   = 2'd0;
  localparam cmd_code_t CMD_SEARCH = 2'd1;
  localparam cmd_code_t CMD_INVAL  = 2'd2;
  localparam cmd_code_t CMD_RANGE  = 2'd3;

  // read address source for the table
  typedef logic [1:0] rd_sel_t;
  localparam rd_sel_t RD_PROBE  = 2'd0;
  localparam rd_sel_t RD_INC    = 2'd1;
  localparam rd_sel_t RD_HITDEC = 2'd2;
  localparam rd_sel_t RD_DEC    = 2'd3;

  typedef struct packed {
    logic    idle;
    logic    clr_wr;
    logic    ld_wr;
    logic    step;
    rd_sel_t sel;
    logic    go_left;
    logic    go_right;
    logic    set_hit;
    logic    inval_wr;
    logic    set_hi;
    logic    set_lo;
    logic    out_load;
  } stsh_cmd_t;

  typedef struct packed {
    logic      accept;
    cmd_code_t in_cmd;
    cmd_code_t cmd;
    logic      p_zero;
    logic      rd_valid;
    logic      key_eq;
    logic      key_lt;
    logic      pos_next_ok;
    logic      hit_zero;
    logic      pos_zero;
    logic      clr_done;
    logic      out_free;
  } stsh_stat_t;

endpackage

FILE: src/stsh_ifs.sv
interface stsh_req_if import stsh_pkg::*;;
  logic      valid;
  logic      ready;
  cmd_code_t cmd;
  idx_t      entry_index;
  key_t      key;
  logic      entry_valid;

  modport source (output valid, cmd, entry_index, key, entry_valid, input ready);
  modport sink (input valid, cmd, entry_index, key, entry_valid, output ready);
endinterface

interface stsh_rsp_if import stsh_pkg::*;;
  logic valid;
  logic ready;
  logic found;
  idx_t match_index;
  idx_t range_low;
  idx_t range_high;

  modport source (output valid, found, match_index, range_low, range_high, input ready);
  modport sink (input valid, found, match_index, range_low, range_high, output ready);
endinterface

FILE: src/stsh_dp.sv
module stsh_dp import stsh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  cnt_t       cfg_wdata,
  stsh_req_if.sink   req,
  stsh_rsp_if.source rsp,
  input  stsh_cmd_t  cmd,
  output stsh_stat_t stat
);

  logic [KEY_W:0] mem [TABLE_DEPTH];
  logic [KEY_W:0] rd_data;

  cnt_t      entry_count;
  idx_t      clr_cnt;
  logic      out_valid;

  cmd_code_t cmd_q;
  key_t      key_q;
  idx_t      idx_q;
  logic      ev_q;
  cnt_t      n_q;
  cnt_t      l;
  cnt_t      r;
  cnt_t      probe_q;
  cnt_t      pos;
  idx_t      hit;
  idx_t      lo;
  idx_t      hi;
  logic      found_q;

  logic      found_o;
  idx_t      match_o;
  idx_t      low_o;
  idx_t      high_o;

  cnt_t      n_eff;
  cnt_t      half;
  cnt_t      rd_addr;
  cnt_t      pos_inc;
  logic      accept;
  logic      wr_en;
  idx_t      wr_addr;
  logic [KEY_W:0] wr_data;

  assign accept    = req.valid && req.ready;
  assign req.ready = cmd.idle;
  assign n_eff     = (entry_count > cnt_t'(TABLE_DEPTH)) ? cnt_t'(TABLE_DEPTH) : entry_count;
  assign half      = (r - l) >> 1;
  assign pos_inc   = pos + cnt_t'(1);

  always_comb begin
    unique case (cmd.sel)
      RD_PROBE:  rd_addr = l + half - cnt_t'(1);
      RD_INC:    rd_addr = pos_inc;
      RD_HITDEC: rd_addr = {1'b0, hit} - cnt_t'(1);
      RD_DEC:    rd_addr = pos - cnt_t'(1);
      default:   rd_addr = pos;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt;
    wr_data = '0;
    priority if (cmd.clr_wr) begin
      wr_en = 1'b1;
    end else if (cmd.ld_wr) begin
      wr_en   = 1'b1;
      wr_addr = idx_q;
      wr_data = {key_q, ev_q};
    end else if (cmd.inval_wr) begin
      wr_en   = 1'b1;
      wr_addr = pos[IDX_W-1:0];
      wr_data = {rd_data[KEY_W:1], 1'b0};
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      clr_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) entry_count <= cfg_wdata;
      if (cmd.clr_wr) clr_cnt <= clr_cnt + idx_t'(1);
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= req.cmd;
      key_q   <= req.key;
      idx_q   <= req.entry_index;
      ev_q    <= req.entry_valid;
      n_q     <= n_eff;
      l       <= '0;
      r       <= n_eff + cnt_t'(1);
      found_q <= 1'b0;
      hit     <= '0;
      lo      <= '0;
      hi      <= '0;
    end
    if (cmd.step) begin
      pos <= rd_addr;
      if (cmd.sel == RD_PROBE) probe_q <= l + half;
    end
    if (cmd.go_left) l <= probe_q;
    if (cmd.go_right) r <= probe_q;
    if (cmd.set_hit) begin
      found_q <= 1'b1;
      hit     <= pos[IDX_W-1:0];
      lo      <= pos[IDX_W-1:0];
      hi      <= pos[IDX_W-1:0];
    end
    if (cmd.set_hi) hi <= pos[IDX_W-1:0];
    if (cmd.set_lo) lo <= pos[IDX_W-1:0];
    if (cmd.out_load) begin
      found_o <= found_q;
      match_o <= hit;
      low_o   <= (cmd_q == CMD_RANGE) ? lo : '0;
      high_o  <= (cmd_q == CMD_RANGE) ? hi : '0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.found       = found_o;
  assign rsp.match_index = match_o;
  assign rsp.range_low   = low_o;
  assign rsp.range_high  = high_o;

  assign stat.accept      = accept;
  assign stat.in_cmd      = req.cmd;
  assign stat.cmd         = cmd_q;
  assign stat.p_zero      = (half == '0);
  assign stat.rd_valid    = rd_data[0];
  assign stat.key_eq      = (rd_data[KEY_W:1] == key_q);
  assign stat.key_lt      = (rd_data[KEY_W:1] < key_q);
  assign stat.pos_next_ok = (pos_inc < n_q);
  assign stat.hit_zero    = (hit == '0);
  assign stat.pos_zero    = (pos == '0);
  assign stat.clr_done    = (clr_cnt == idx_t'(TABLE_DEPTH - 1));
  assign stat.out_free    = !out_valid || rsp.ready;

endmodule

FILE: src/stsh_ctrl.sv
module stsh_ctrl import stsh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  stsh_stat_t stat,
  output stsh_cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_LOAD    = 4'd2;
  localparam logic [3:0] S_PROBE   = 4'd3;
  localparam logic [3:0] S_CHECK   = 4'd4;
  localparam logic [3:0] S_UP      = 4'd5;
  localparam logic [3:0] S_DNSTART = 4'd6;
  localparam logic [3:0] S_DN      = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.sel    = RD_PROBE;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (stat.accept) state_next = (stat.in_cmd == CMD_LOAD) ? S_LOAD : S_PROBE;
      end
      S_LOAD: begin
        cmd.ld_wr  = 1'b1;
        state_next = S_DONE;
      end
      S_PROBE: begin
        if (stat.p_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (!stat.rd_valid) begin
          // skip the hole, or treat the probe as above when the table ends
          if (stat.pos_next_ok) begin
            cmd.step = 1'b1;
            cmd.sel  = RD_INC;
          end else begin
            cmd.go_right = 1'b1;
            state_next   = S_PROBE;
          end
        end else if (stat.key_lt) begin
          cmd.go_left = 1'b1;
          state_next  = S_PROBE;
        end else if (!stat.key_eq) begin
          cmd.go_right = 1'b1;
          state_next   = S_PROBE;
        end else begin
          cmd.set_hit = 1'b1;
          priority if (stat.cmd == CMD_INVAL) begin
            cmd.inval_wr = 1'b1;
            state_next   = S_DONE;
          end else if (stat.cmd == CMD_RANGE) begin
            if (stat.pos_next_ok) begin
              cmd.step   = 1'b1;
              cmd.sel    = RD_INC;
              state_next = S_UP;
            end else begin
              state_next = S_DNSTART;
            end
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_UP: begin
        if (stat.rd_valid && !stat.key_eq) begin
          state_next = S_DNSTART;
        end else begin
          cmd.set_hi = stat.rd_valid;
          if (stat.pos_next_ok) begin
            cmd.step = 1'b1;
            cmd.sel  = RD_INC;
          end else begin
            state_next = S_DNSTART;
          end
        end
      end
      S_DNSTART: begin
        if (stat.hit_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.step   = 1'b1;
          cmd.sel    = RD_HITDEC;
          state_next = S_DN;
        end
      end
      S_DN: begin
        if (stat.rd_valid && !stat.key_eq) begin
          state_next = S_DONE;
        end else begin
          cmd.set_lo = stat.rd_valid;
          if (!stat.pos_zero) begin
            cmd.step = 1'b1;
            cmd.sel  = RD_DEC;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: src/sorted_table_search_with_holes.sv
// Sorted key table with holes, searched by bisection.
// Request channel (req) carries cmd, entry_index, key and entry_valid; every
// transaction produces exactly one response transaction on rsp (found,
// match_index, range_low, range_high). cfg_we/cfg_wdata set entry_count.
// Load writes one table entry and answers with an all-zero response.
// Search, invalidate and range search bisect over the first entry_count
// entries; each probe reads the table one entry per cycle, skipping entries
// whose valid bit is clear.
// A search makes about log2(entry_count) probes; each probe reads the probe
// entry and any skipped holes. A range search then walks the entries on
// each side of the match. The single table read port sets the pace.
// One request is worked at a time; the next is taken as soon as the result
// sits in the output register, even if rsp is stalled. A stalled receiver
// only holds the block in its final step until the output register drains.
// After reset the table valid bits are cleared, during which req.ready stays
// low; configuration writes are accepted throughout.
module sorted_table_search_with_holes import stsh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  cnt_t       cfg_wdata,
  stsh_req_if.sink   req,
  stsh_rsp_if.source rsp
);

  stsh_cmd_t  cmd;
  stsh_stat_t stat;

  stsh_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  stsh_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
